@@ design/ckc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_pkg
// Shared constants, payload types and helper functions of the canonical
// k-mer counter.
// ----------------------------------------------------------------------------
package ckc_pkg;

    localparam int MAX_WORD    = 8;
    localparam int COUNT_BITS  = 32;
    localparam int WORD_BITS   = 2 * MAX_WORD;
    localparam int TABLE_AW    = WORD_BITS;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int WIN_W       = $clog2(MAX_WORD + 1);

    // Queue depths are kept at powers of two.
    localparam int CMD_DEPTH = 4;
    localparam int CMD_AW    = $clog2(CMD_DEPTH);
    localparam int CMD_CW    = $clog2(CMD_DEPTH + 1);
    localparam int OUT_DEPTH = 4;
    localparam int OUT_AW    = $clog2(OUT_DEPTH);
    localparam int OUT_CW    = $clog2(OUT_DEPTH + 1);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WORD_LENGTH = 3'd0,
        CFG_CODE_A      = 3'd1,
        CFG_CODE_C      = 3'd2,
        CFG_CODE_G      = 3'd3,
        CFG_CODE_T      = 3'd4
    } t_cfg_reg;

    localparam logic [7:0] CH_HEADER   = 8'h3E;
    localparam logic [7:0] CH_NEWLINE  = 8'h0A;
    localparam logic [7:0] CH_UPPER_A  = 8'h41;
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
    localparam logic [7:0] CH_CASE_OFS = 8'h20;
    localparam logic [7:0] CH_A        = 8'h61;
    localparam logic [7:0] CH_C        = 8'h63;
    localparam logic [7:0] CH_G        = 8'h67;
    localparam logic [7:0] CH_T        = 8'h74;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [1:0] {
        OP_NONE = 2'd0,
        OP_BUMP = 2'd1,
        OP_READ = 2'd2
    } t_op;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef struct packed {
        logic        action;
        logic [7:0]  symbol;
        logic [15:0] entry_index;
    } t_item;

    typedef struct packed {
        logic [15:0] forward_index;
        logic [15:0] reverse_index;
        logic        counted;
        logic [31:0] entry_count;
        logic [31:0] sequence_length;
    } t_result;

    typedef struct packed {
        t_op                  op;
        logic [WORD_BITS-1:0] fwd_word;
        logic [WORD_BITS-1:0] rev_word;
        logic [TABLE_AW-1:0]  read_addr;
        logic                 counted;
        logic [31:0]          seq_len;
    } t_cmd;

    function automatic t_count sat_inc(input t_count c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Narrows a bin count to the 32-bit result field, saturating.
    function automatic logic [31:0] report_count(input t_count c);
        logic [COUNT_BITS+31:0] wide;
        wide = (COUNT_BITS + 32)'(c);
        if (wide > (COUNT_BITS + 32)'(32'hFFFF_FFFF)) begin
            return 32'hFFFF_FFFF;
        end
        return wide[31:0];
    endfunction

endpackage

@@ design/canonical_kmer_counter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canonical_kmer_counter_core
// Counts forward and reverse-complement k-mers of a FASTA character stream.
// ----------------------------------------------------------------------------
// Input queue: an item (a character push, or a read-and-clear of one bin)
// is taken on a clock edge with push high and full low. Results come out of
// a queue: while empty is low the oldest result is on o_result, and pop
// takes it. Every item gives exactly one result, in order.
// Configuration: a write is taken when i_cfg_valid is high (ready is always
// high); writes are meant for an idle block.
// Path: an item passes the command queue, the table read and the stage-1
// register into the result queue; a counted base does the table step per bin.
// Throughput: one item per cycle while the table is not swept and no queue
// stalls; a counted base is issued twice, as the count memory takes one
// read-modify-write per cycle and a base updates two bins.
// Reset: synchronous, active low. After it the count table is swept to zero,
// one bin per cycle over all 65536 bins; full stays high until the sweep ends.
// Stall: if pop is held low the result queue fills and the table pipeline
// stops issuing; the 4-deep command queue then fills and full rises.
// ----------------------------------------------------------------------------
module canonical_kmer_counter_core
    import ckc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  push,
    output logic                  full,
    input  t_item                 i_item,
    output logic                  empty,
    input  logic                  pop,
    output t_result               o_result,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic accept;
    t_cmd front_cmd;
    logic cmd_full;
    logic cmd_valid;
    t_cmd cmd_head;
    logic cmd_pop;
    logic clearing;

    assign full        = cmd_full || clearing;
    assign o_cfg_ready = 1'b1;

    ckc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_block     (full),
        .o_accept    (accept),
        .o_cmd       (front_cmd),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    ckc_cmd_queue u_cmd_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_cmd   (front_cmd),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_valid (cmd_valid),
        .o_head  (cmd_head)
    );

    ckc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd_head),
        .o_cmd_pop   (cmd_pop),
        .o_clearing  (clearing),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

@@ design/ckc_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_front
// Accepts characters and read requests, tracks the sequence and k-mer window
// state, holds the configuration registers and emits one command per item.
// ----------------------------------------------------------------------------
module ckc_front
    import ckc_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_item                 i_item,
    input  logic                  i_block,
    output logic                  o_accept,
    output t_cmd                  o_cmd,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [3:0]           r_word_length;
    logic [1:0]           r_code_a, r_code_c, r_code_g, r_code_t;
    logic                 r_in_header, n_in_header;
    logic [WORD_BITS-1:0] r_fwd, n_fwd;
    logic [WORD_BITS-1:0] r_rev, n_rev;
    logic [WIN_W-1:0]     r_win, n_win;
    logic [31:0]          r_seen, n_seen;

    logic [WIN_W-1:0]     eff_k;
    logic [WORD_BITS:0]   one_sh;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] rev_top;
    logic [7:0]           sym_lc;
    logic [1:0]           code;
    logic                 is_base;
    logic                 counted;
    logic                 wl_write;

    assign o_accept = i_push && !i_block;
    assign wl_write = i_cfg_valid && (i_cfg_index == CFG_WORD_LENGTH);

    always_comb begin
        if (r_word_length == 4'd0) begin
            eff_k = WIN_W'(1);
        end else if (r_word_length > 4'(MAX_WORD)) begin
            eff_k = WIN_W'(MAX_WORD);
        end else begin
            eff_k = WIN_W'(r_word_length);
        end
    end

    always_comb begin
        if (i_item.symbol >= CH_UPPER_A && i_item.symbol <= CH_UPPER_Z) begin
            sym_lc = i_item.symbol + CH_CASE_OFS;
        end else begin
            sym_lc = i_item.symbol;
        end
        is_base = 1'b1;
        case (sym_lc)
            CH_A:    code = r_code_a;
            CH_C:    code = r_code_c;
            CH_G:    code = r_code_g;
            CH_T:    code = r_code_t;
            default: begin
                code    = 2'd0;
                is_base = 1'b0;
            end
        endcase
    end

    assign one_sh  = (WORD_BITS + 1)'(1) << {eff_k, 1'b0};
    assign mask    = WORD_BITS'(one_sh - 1'b1);
    assign rev_top = WORD_BITS'(2'd3 - code) << {eff_k - 1'b1, 1'b0};

    always_comb begin
        n_in_header = r_in_header;
        n_fwd       = r_fwd;
        n_rev       = r_rev;
        n_win       = r_win;
        n_seen      = r_seen;
        counted     = 1'b0;
        o_cmd.op    = OP_NONE;
        if (o_accept) begin
            if (i_item.action == ACT_READ) begin
                o_cmd.op = OP_READ;
            end else if (r_in_header) begin
                if (i_item.symbol == CH_NEWLINE) begin
                    n_in_header = 1'b0;
                end
            end else if (i_item.symbol == CH_HEADER) begin
                n_in_header = 1'b1;
                n_fwd       = '0;
                n_rev       = '0;
                n_win       = '0;
                n_seen      = '0;
            end else if (is_base) begin
                n_fwd = ((r_fwd << 2) | WORD_BITS'(code)) & mask;
                n_rev = ((r_rev >> 2) | rev_top) & mask;
                if (r_win < eff_k) begin
                    n_win = r_win + 1'b1;
                end
                if (r_seen != '1) begin
                    n_seen = r_seen + 1'b1;
                end
                if (n_win >= eff_k) begin
                    counted  = 1'b1;
                    o_cmd.op = OP_BUMP;
                end
            end
        end
        // Rewriting the word length restarts the window.
        if (wl_write) begin
            n_fwd = '0;
            n_rev = '0;
            n_win = '0;
        end
        o_cmd.fwd_word  = n_fwd;
        o_cmd.rev_word  = n_rev;
        o_cmd.read_addr = TABLE_AW'(i_item.entry_index);
        o_cmd.counted   = counted;
        o_cmd.seq_len   = n_seen;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_length <= 4'd8;
            r_code_a      <= 2'd0;
            r_code_c      <= 2'd1;
            r_code_g      <= 2'd2;
            r_code_t      <= 2'd3;
            r_in_header   <= 1'b0;
            r_fwd         <= '0;
            r_rev         <= '0;
            r_win         <= '0;
            r_seen        <= '0;
        end else begin
            r_in_header <= n_in_header;
            r_fwd       <= n_fwd;
            r_rev       <= n_rev;
            r_win       <= n_win;
            r_seen      <= n_seen;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_WORD_LENGTH: r_word_length <= i_cfg_data;
                    CFG_CODE_A:      r_code_a      <= i_cfg_data[1:0];
                    CFG_CODE_C:      r_code_c      <= i_cfg_data[1:0];
                    CFG_CODE_G:      r_code_g      <= i_cfg_data[1:0];
                    CFG_CODE_T:      r_code_t      <= i_cfg_data[1:0];
                    default: begin
                    end
                endcase
            end
        end
    end

endmodule

@@ design/ckc_cmd_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_cmd_queue
// Short command queue between the classifying front end and the table
// update back end.
// ----------------------------------------------------------------------------
module ckc_cmd_queue
    import ckc_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_head
);

    t_cmd              r_mem [CMD_DEPTH];
    logic [CMD_AW-1:0] r_wp, r_rp;
    logic [CMD_CW-1:0] r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == CMD_CW'(CMD_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

@@ design/ckc_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_back
// Runs the commands against the count table: a two-stage read-modify-write
// pipeline with one write-forwarding register, a clearing sweep after reset
// and the result queue.
// ----------------------------------------------------------------------------
module ckc_back
    import ckc_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cmd_valid,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    output logic    o_clearing,
    output t_result o_result,
    output logic    o_empty,
    input  logic    i_pop
);

    t_count              mem [TABLE_DEPTH];
    t_count              r_rd_data;

    logic                r_clearing;
    logic [TABLE_AW-1:0] r_clr_addr;
    logic                r_phase;

    logic                r_s1_valid;
    logic                r_s1_last;
    logic [TABLE_AW-1:0] r_s1_addr;
    t_cmd                r_s1_cmd;

    logic                r_wr_valid;
    logic [TABLE_AW-1:0] r_wr_addr;
    t_count              r_wr_data;

    t_result             r_out_mem [OUT_DEPTH];
    logic [OUT_AW-1:0]   r_out_wp, r_out_rp;
    logic [OUT_CW-1:0]   r_out_cnt;

    logic                credit_ok;
    logic                issue;
    logic                is_last;
    logic [TABLE_AW-1:0] rd_addr;
    t_count              old_val;
    t_count              new_val;
    logic                we;
    logic                out_push;
    logic                out_pop;
    t_result             result;

    assign o_clearing = r_clearing;

    // A result slot is reserved for every final beat still in the pipeline.
    assign credit_ok = ((OUT_CW + 1)'(r_out_cnt) + (OUT_CW + 1)'(r_s1_valid && r_s1_last))
                       < (OUT_CW + 1)'(OUT_DEPTH);
    assign issue     = i_cmd_valid && !r_clearing && credit_ok;
    assign is_last   = (i_cmd.op != OP_BUMP) || r_phase;
    assign o_cmd_pop = issue && is_last;

    always_comb begin
        case (i_cmd.op)
            OP_READ: rd_addr = i_cmd.read_addr;
            OP_BUMP: rd_addr = r_phase ? TABLE_AW'(i_cmd.rev_word) : TABLE_AW'(i_cmd.fwd_word);
            default: rd_addr = i_cmd.read_addr;
        endcase
    end

    // The read issued in the previous cycle misses the write made in that cycle.
    assign old_val = (r_wr_valid && r_wr_addr == r_s1_addr) ? r_wr_data : r_rd_data;
    assign new_val = (r_s1_cmd.op == OP_READ) ? '0 : sat_inc(old_val);
    assign we      = r_s1_valid && (r_s1_cmd.op != OP_NONE);

    always_comb begin
        result.forward_index   = 16'(r_s1_cmd.fwd_word);
        result.reverse_index   = 16'(r_s1_cmd.rev_word);
        result.counted         = r_s1_cmd.counted;
        result.entry_count     = (r_s1_cmd.op == OP_READ) ? report_count(old_val) : 32'd0;
        result.sequence_length = r_s1_cmd.seq_len;
    end

    assign out_push = r_s1_valid && r_s1_last;
    assign out_pop  = i_pop && !o_empty;
    assign o_empty  = (r_out_cnt == '0);
    assign o_result = r_out_mem[r_out_rp];

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (we) begin
            mem[r_s1_addr] <= new_val;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= rd_addr;
        r_s1_cmd  <= i_cmd;
        r_wr_addr <= r_s1_addr;
        r_wr_data <= new_val;
        if (out_push) begin
            r_out_mem[r_out_wp] <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_phase    <= 1'b0;
            r_s1_valid <= 1'b0;
            r_s1_last  <= 1'b0;
            r_wr_valid <= 1'b0;
            r_out_wp   <= '0;
            r_out_rp   <= '0;
            r_out_cnt  <= '0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            if (issue) begin
                r_phase <= !is_last;
            end
            r_s1_valid <= issue;
            r_s1_last  <= is_last;
            r_wr_valid <= we;
            if (out_push) begin
                r_out_wp <= r_out_wp + 1'b1;
            end
            if (out_pop) begin
                r_out_rp <= r_out_rp + 1'b1;
            end
            if (out_push && !out_pop) begin
                r_out_cnt <= r_out_cnt + 1'b1;
            end else if (out_pop && !out_push) begin
                r_out_cnt <= r_out_cnt - 1'b1;
            end
        end
    end

endmodule

@@ design/ckc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ckc_checker
// Port-level checks of the canonical k-mer counter, bound to the top level.
// ----------------------------------------------------------------------------
module ckc_checker
    import ckc_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    full,
    input logic    empty,
    input logic    pop,
    input t_result o_result
);

    // The table sweep after reset keeps the input closed.
    a_full_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> full)
        else $error("input open right after reset");

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("result shown right after reset");

    // A counting character never reports a bin count.
    a_counted_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_result.counted) |-> (o_result.entry_count == 32'd0))
        else $error("counted result carries a bin count");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_result)))
        else $error("waiting result changed or vanished");

endmodule

bind canonical_kmer_counter_core ckc_checker u_ckc_checker (.*);
